// ----- src/assert_macros.svh -----
// shared assertion macros, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define A_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define A_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define A_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define A_ALWAYS(lbl, expr)
`define A_IMPLIES(lbl, ante, cons)
`define A_NEXT(lbl, ante, cons)

`endif

`endif

// ----- src/pfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  localparam int SIZE_W = 16;
  localparam int ID_W   = 8;

  localparam logic       OP_APPEND = 1'b0;
  localparam logic       OP_ALLOC  = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_ADDED     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } pfa_state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } part_ent_t;

  typedef struct packed {
    logic              busy;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } part_rd_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
  } fit_res_t;

endpackage

`default_nettype wire

// ----- src/partition_fit_allocator_top.sv -----
// append: the item is taken in S_IDLE and its result is loaded into the output register in S_RESP
// allocate: the item goes through S_SCAN, then its result is loaded into the output register in S_RESP;
//   the table is walked one entry a cycle through a single read port and one comparator
// a new item is taken only in S_IDLE, once the result of the last one has been loaded
// reset (synchronous, rst_n low): clears occupancy, part count and fit mode;
//   partition sizes and ids are not cleared
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module partition_fit_allocator_top #(
  parameter int MAX_PARTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_item_id,
  input  logic [15:0] in_size_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_chosen_block_id,
  output logic [3:0] out_chosen_index
);
  import pfa_pkg::*;

  localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_PARTS + 1);

  pfa_state_t        state_r, state_nxt;
  logic [1:0]        fit_mode_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     scan_idx_r, scan_idx_nxt;
  logic              op_r;
  logic              full_r;
  logic [SIZE_W-1:0] need_r;
  logic              rd_vld_r;
  logic [IW-1:0]     rd_idx_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [3:0]        out_idx_r;

  logic              accept;
  logic              is_full;
  logic              wr_en;
  part_ent_t         wr_data;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  part_rd_t          rd_data;
  logic              out_load;
  logic              set_en;
  logic              fit_clear;
  fit_res_t          fit_res;
  logic [IW-1:0]     best_idx;
  logic [1:0]        res_status;
  logic [ID_W-1:0]   res_id;
  logic [3:0]        res_idx;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_full  = (cnt_r == CW'(MAX_PARTS));
  assign wr_en    = accept && (in_opcode == OP_APPEND) && !is_full;
  assign wr_data  = '{id: in_item_id, size: in_size_value};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_opcode == OP_ALLOC) ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_idx_r == cnt_r) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_en        = 1'b0;
    out_load     = 1'b0;
    fit_clear    = 1'b0;
    scan_idx_nxt = scan_idx_r;
    case (state_r)
      S_IDLE: begin
        fit_clear    = 1'b1;
        scan_idx_nxt = '0;
      end
      S_SCAN: begin
        if (scan_idx_r != cnt_r) begin
          rd_en        = 1'b1;
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
      end
      S_RESP: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  assign rd_addr = scan_idx_r[IW-1:0];
  assign set_en  = out_load && (op_r == OP_ALLOC) && fit_res.found;

  always_comb begin
    res_id  = '0;
    res_idx = '0;
    if (op_r == OP_APPEND) begin
      res_status = full_r ? ST_FULL : ST_ADDED;
    end else if (fit_res.found) begin
      res_status = ST_ALLOCATED;
      res_id     = fit_res.id;
      res_idx    = 4'(best_idx);
    end else begin
      res_status = ST_NO_FIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fit_mode_r  <= FIT_FIRST;
      cnt_r       <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      rd_vld_r   <= rd_en;
      if (cfg_wr_en) begin
        fit_mode_r <= cfg_wr_data;
      end
      if (wr_en) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      need_r <= in_size_value;
      full_r <= is_full;
    end
    rd_idx_r <= rd_addr;
    if (out_load) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_idx_r    <= res_idx;
    end
  end

  pfa_table #(
    .MAX_PARTS (MAX_PARTS),
    .IW        (IW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (cnt_r[IW-1:0]),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .set_en   (set_en),
    .set_addr (best_idx)
  );

  pfa_fit_unit #(
    .IW (IW)
  ) u_fit (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (fit_clear),
    .rd_vld   (rd_vld_r),
    .rd_data  (rd_data),
    .rd_idx   (rd_idx_r),
    .need     (need_r),
    .mode     (fit_mode_r),
    .res      (fit_res),
    .best_idx (best_idx)
  );

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_chosen_block_id = out_id_r;
  assign out_chosen_index    = out_idx_r;

  `A_ALWAYS(a_cnt_bound, cnt_r <= CW'(MAX_PARTS))
  `A_IMPLIES(a_scan_bound, state_r == S_SCAN, scan_idx_r <= cnt_r)
  `A_IMPLIES(a_rd_in_scan, rd_vld_r, state_r == S_SCAN)
  `A_NEXT(a_append_grows, wr_en, cnt_r == $past(cnt_r) + CW'(1))

endmodule

`default_nettype wire

// ----- src/pfa_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfa_table #(
  parameter int MAX_PARTS = 16,
  parameter int IW        = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [IW-1:0]      wr_addr,
  input  pfa_pkg::part_ent_t wr_data,
  input  logic               rd_en,
  input  logic [IW-1:0]      rd_addr,
  output pfa_pkg::part_rd_t  rd_data,
  input  logic               set_en,
  input  logic [IW-1:0]      set_addr
);
  import pfa_pkg::*;

  part_ent_t              mem [MAX_PARTS];
  logic [MAX_PARTS-1:0]   busy_r;
  part_rd_t               rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r.id   <= mem[rd_addr].id;
      rd_r.size <= mem[rd_addr].size;
      rd_r.busy <= busy_r[rd_addr];
    end
  end

  // occupancy flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      if (wr_en) begin
        busy_r[wr_addr] <= 1'b0;
      end
      if (set_en) begin
        busy_r[set_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_r;

endmodule

`default_nettype wire

// ----- src/pfa_fit_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfa_fit_unit #(
  parameter int IW = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       rd_vld,
  input  pfa_pkg::part_rd_t          rd_data,
  input  logic [IW-1:0]              rd_idx,
  input  logic [pfa_pkg::SIZE_W-1:0] need,
  input  logic [1:0]                 mode,
  output pfa_pkg::fit_res_t          res,
  output logic [IW-1:0]              best_idx
);
  import pfa_pkg::*;

  logic              have_r,  have_nxt;
  logic [SIZE_W-1:0] left_r,  left_nxt;
  logic [IW-1:0]     idx_r,   idx_nxt;
  logic [ID_W-1:0]   id_r,    id_nxt;
  logic              fits;
  logic              better;
  logic              take;
  logic [SIZE_W-1:0] left;

  // one subtract and compare per entry
  always_comb begin
    fits = !rd_data.busy && (rd_data.size >= need);
    left = rd_data.size - need;
    case (mode)
      FIT_BEST:  better = left < left_r;
      FIT_WORST: better = left >= left_r;
      default:   better = 1'b0;
    endcase
    take = rd_vld && fits && (!have_r || better);
  end

  always_comb begin
    have_nxt = have_r;
    left_nxt = left_r;
    idx_nxt  = idx_r;
    id_nxt   = id_r;
    if (clear) begin
      have_nxt = 1'b0;
    end else if (take) begin
      have_nxt = 1'b1;
      left_nxt = left;
      idx_nxt  = rd_idx;
      id_nxt   = rd_data.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    idx_r  <= idx_nxt;
    id_r   <= id_nxt;
  end

  assign res.found = have_r;
  assign res.id    = id_r;
  assign best_idx  = idx_r;

endmodule

`default_nettype wire

// ----- bench/pfa_checker.sv -----
`timescale 1ns / 1ps

module pfa_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_item_id,
  input  logic [15:0] in_size_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_chosen_block_id,
  input  logic [3:0]  out_chosen_index,
  output int          mismatches,
  output int          outstanding
);
  import pfa_pkg::*;

  localparam int PARTS = 16;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] block_id;
    logic [3:0] index;
  } reply_t;

  logic [15:0] tbl_size [PARTS];
  logic [7:0]  tbl_id [PARTS];
  logic        tbl_busy [PARTS];
  logic [4:0]  tbl_count;
  logic [1:0]  fit_sel;
  reply_t      replies_due [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // updates the partition table and returns the reply the block owes for this item
  function automatic reply_t place_item(input logic op, input logic [7:0] id,
                                        input logic [15:0] need);
    reply_t      r;
    int          pick;
    logic [15:0] left;
    logic [15:0] best_left;
    r = '0;
    pick = -1;
    best_left = '0;
    if (op == OP_APPEND) begin
      if (tbl_count >= PARTS) begin
        r.status = ST_FULL;
      end else begin
        tbl_id[tbl_count[3:0]] = id;
        tbl_size[tbl_count[3:0]] = need;
        tbl_busy[tbl_count[3:0]] = 1'b0;
        tbl_count = tbl_count + 5'd1;
        r.status = ST_ADDED;
      end
    end else begin
      for (int i = 0; i < PARTS; i++) begin
        if (i < tbl_count && !tbl_busy[i] && tbl_size[i] >= need) begin
          left = tbl_size[i] - need;
          case (fit_sel)
            FIT_BEST: begin
              if (pick < 0 || left < best_left) begin
                pick = i;
                best_left = left;
              end
            end
            // ties go to the later entry
            FIT_WORST: begin
              if (pick < 0 || left >= best_left) begin
                pick = i;
                best_left = left;
              end
            end
            default: begin
              if (pick < 0) pick = i;
            end
          endcase
        end
      end
      if (pick < 0) begin
        r.status = ST_NO_FIT;
      end else begin
        tbl_busy[pick] = 1'b1;
        r.status = ST_ALLOCATED;
        r.block_id = tbl_id[pick];
        r.index = pick[3:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      tbl_count = '0;
      fit_sel = FIT_FIRST;
      for (int i = 0; i < PARTS; i++) tbl_busy[i] = 1'b0;
      replies_due.delete();
    end else begin
      if (cfg_wr_en) fit_sel = cfg_wr_data;
      if (in_valid && !in_stall)
        replies_due = {replies_due, place_item(in_opcode, in_item_id, in_size_value)};
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("result item with nothing expected");
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_chosen_block_id !== want.block_id)
            flag_mismatch($sformatf("block id got %0d want %0d",
                                    out_chosen_block_id, want.block_id));
          if (out_chosen_index !== want.index)
            flag_mismatch($sformatf("index got %0d want %0d",
                                    out_chosen_index, want.index));
        end
      end
    end
    outstanding <= replies_due.size();
  end

endmodule

// ----- bench/partition_fit_allocator_top_test.sv -----
`timescale 1ns / 1ps

module partition_fit_allocator_top_test;
  import pfa_pkg::*;

  // the spare mode value, handled as first fit
  localparam logic [1:0] FIT_SPARE = 2'd3;
  localparam int RAND_PHASE_ITEMS = 255;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_opcode = 1'b0;
  logic [7:0]  in_item_id = '0;
  logic [15:0] in_size_value = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_chosen_block_id;
  logic [3:0]  out_chosen_index;
  int          mismatches;
  int          outstanding;
  int          in_gap_max = 17;
  int          out_gap_max = 17;
  int          sent = 0;

  partition_fit_allocator_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_item_id          (in_item_id),
    .in_size_value       (in_size_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_chosen_block_id (out_chosen_block_id),
    .out_chosen_index    (out_chosen_index)
  );

  pfa_checker chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_item_id          (in_item_id),
    .in_size_value       (in_size_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_chosen_block_id (out_chosen_block_id),
    .out_chosen_index    (out_chosen_index),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** partition_fit_allocator_top: FAILED **");
    $finish;
  end

  // valid stays up across back-to-back items, so it is only lowered for a real gap
  task automatic push_item(input logic op, input logic [7:0] id, input logic [15:0] sz);
    int gap;
    if (sent % 50 == 0) in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_item_id <= id;
    in_size_value <= sz;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // an allocate walks at most 16 entries
    repeat (24) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int n;
    int served;
    served = 0;
    wait (rst_n);
    forever begin
      if (served % 40 == 0) out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      n = $urandom_range(0, out_gap_max);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  initial begin
    logic [15:0] sz;
    logic [1:0]  mode;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(FIT_FIRST);

    push_item(OP_ALLOC, 8'd7, 16'd0);  // empty table
    for (int k = 0; k < 16; k++) begin
      case (k)
        0:       sz = 16'd0;
        1:       sz = 16'd65535;
        2, 4:    sz = 16'd100;
        3, 5:    sz = 16'd300;
        6, 7:    sz = 16'd60000;
        8, 9:    sz = 16'd5;
        10, 12:  sz = 16'd1000;
        11:      sz = 16'd2000;
        13, 14:  sz = 16'd40000;
        default: sz = 16'd7;
      endcase
      push_item(OP_APPEND, (k == 1) ? 8'd255 : 8'(k * 13), sz);
    end
    push_item(OP_APPEND, 8'hAA, 16'hFFFF);  // table full
    push_item(OP_ALLOC, 8'd255, 16'd0);     // zero request takes the zero-size entry
    settle();

    write_mode(FIT_BEST);
    push_item(OP_ALLOC, 8'd1, 16'd100);     // equal leftovers, earlier entry wins
    push_item(OP_ALLOC, 8'd2, 16'd65535);
    settle();

    write_mode(FIT_WORST);
    push_item(OP_ALLOC, 8'd3, 16'd10);      // equal leftovers, later entry wins
    push_item(OP_ALLOC, 8'd4, 16'd10);
    push_item(OP_ALLOC, 8'd5, 16'd65535);   // largest entry already taken
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       mode = FIT_SPARE;
        1:       mode = FIT_BEST;
        2:       mode = FIT_FIRST;
        3:       mode = FIT_WORST;
        default: mode = FIT_SPARE;
      endcase
      write_mode(mode);
      for (int k = 0; k < RAND_PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 7) == 0) sz = 16'($urandom_range(0, 3000));
        else sz = 16'($urandom_range(0, 65535));
        push_item(($urandom_range(0, 3) == 0) ? OP_APPEND : OP_ALLOC,
                  8'($urandom_range(0, 255)), sz);
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("** partition_fit_allocator_top: PASSED **");
    end else begin
      $display("** partition_fit_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule
